### hw/rtl/ecwm_pkg.sv
// ----------------------------------------------------------------------------
// Ease curve weight multiplier package
// Shared constants, register indexes and enumerated types.
// ----------------------------------------------------------------------------
package ecwm_pkg;

   localparam int TimeWidthDefault = 32;
   localparam int FracBits         = 16;
   localparam int MultWidth        = 17;
   localparam int PhaseWidth       = 2;
   localparam int CsrAddrWidth     = 5;

   localparam logic [MultWidth-1:0] OneQ16 = 17'h10000;

   typedef enum logic [2:0] {
      REG_IN_START   = 3'd0,
      REG_IN_END     = 3'd1,
      REG_OUT_START  = 3'd2,
      REG_OUT_END    = 3'd3,
      REG_IN_POINTS  = 3'd4,
      REG_OUT_POINTS = 3'd5,
      REG_ENABLES    = 3'd6,
      REG_UNUSED     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      PHASE_ONE   = 2'd0,
      PHASE_OUT   = 2'd1,
      PHASE_BLEND = 2'd2,
      PHASE_IN    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CONST = 2'd0,
      KIND_CURVE = 2'd1,
      KIND_BLEND = 2'd2
   } kind_type;

   localparam logic [31:0] InPointsReset  = 32'hFFFF0000;
   localparam logic [31:0] OutPointsReset = 32'h0000FFFF;

endpackage

### hw/rtl/ecwm_divider.sv
// ----------------------------------------------------------------------------
// Ease curve pipelined fraction divider
// Quotient floor(num*2^16/den), num < den, or 2^16 on in_sat; one bit a stage.
// ----------------------------------------------------------------------------
module ecwm_divider #(
   parameter int DW = 33,
   parameter int TW = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [DW-1:0]              in_num,
   input  logic [DW-1:0]              in_den,
   input  logic                       in_sat,
   input  logic [TW-1:0]              in_tag,
   output logic                       out_valid,
   output logic [ecwm_pkg::FracBits:0] out_quot,
   output logic [TW-1:0]              out_tag
);
   import ecwm_pkg::*;

   localparam int N = FracBits;

   logic [N:0]   valid_ff;
   logic [DW-1:0] rem_ff  [N+1];
   logic [DW-1:0] den_ff  [N+1];
   logic [N-1:0]  quot_ff [N+1];
   logic [N:0]    sat_ff;
   logic [TW-1:0] tag_ff  [N+1];

   logic [DW:0]   shifted [N];
   logic [N-1:0]  take;
   logic [DW-1:0] rem_in  [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[N-1:0], in_valid};
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         shifted[i] = {rem_ff[i], 1'b0};
         take[i]    = shifted[i] >= {1'b0, den_ff[i]};
         rem_in[i]  = take[i] ? DW'(shifted[i] - {1'b0, den_ff[i]}) : shifted[i][DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      quot_ff[0] <= '0;
      sat_ff[0]  <= in_sat;
      tag_ff[0]  <= in_tag;
      for (int i = 0; i < N; i++) begin
         rem_ff[i+1]  <= rem_in[i];
         den_ff[i+1]  <= den_ff[i];
         quot_ff[i+1] <= {quot_ff[i][N-2:0], take[i]};
         sat_ff[i+1]  <= sat_ff[i];
         tag_ff[i+1]  <= tag_ff[i];
      end
   end

   assign out_valid = valid_ff[N];
   assign out_quot  = sat_ff[N] ? OneQ16 : {1'b0, quot_ff[N]};
   assign out_tag   = tag_ff[N];

endmodule

### hw/rtl/ease_curve_weight_multiplier_top.sv
// ----------------------------------------------------------------------------
// Ease curve weight multiplier
// Maps a time sample to a cubic Bezier ease multiplier, with a gap blend.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         start & !busy        req_current_time
// rsp       out        rsp_valid strobe     rsp_multiplier, rsp_phase
// csr       in/out     APB, pready = 1      paddr, pwdata, prdata
//
// One item enters every cycle; busy stays low. An accepted item passes stages
// 1 and 2, the 16-stage divider and the Bernstein multiplier stages A to E.
// Reset clears the valid bits and the configuration registers.
// The receiver cannot stall, so the pipeline always advances.
module ease_curve_weight_multiplier_top #(
   parameter int TIME_WIDTH = ecwm_pkg::TimeWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [TIME_WIDTH-1:0]         req_current_time,
   output logic                                 rsp_valid,
   output logic [ecwm_pkg::MultWidth-1:0]       rsp_multiplier,
   output logic [ecwm_pkg::PhaseWidth-1:0]      rsp_phase,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ecwm_pkg::CsrAddrWidth - (TIME_WIDTH > 32 ? 0 : 1):0] paddr,
   input  logic [TIME_WIDTH > 32 ? 63 : 31:0]   pwdata,
   output logic [TIME_WIDTH > 32 ? 63 : 31:0]   prdata,
   output logic                                 pready
);
   import ecwm_pkg::*;

   localparam int TW  = TIME_WIDTH;
   localparam int DW  = TW + 1;
   localparam int PW  = (TW > 32) ? 64 : 32;
   localparam int AS  = (TW > 32) ? 3 : 2;
   localparam int AW  = CsrAddrWidth + ((TW > 32) ? 1 : 0);
   localparam int TGW = 2 + 1 + 1 + 32 + 8 + 8;

   // Configuration registers.
   logic signed [TW-1:0] in_start_ff, in_end_ff, out_start_ff, out_end_ff;
   logic [31:0]          in_pts_ff, out_pts_ff;
   logic [1:0]           en_ff;
   reg_index_type        widx;
   logic                 wr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr     = psel & penable & pwrite;

   always_comb begin
      widx = REG_UNUSED;
      if (paddr[AW-1:AS] <= (AW-AS)'(6)) begin
         widx = reg_index_type'(3'(paddr[AW-1:AS]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_start_ff  <= '0;
         in_end_ff    <= '0;
         out_start_ff <= '0;
         out_end_ff   <= '0;
         in_pts_ff    <= InPointsReset;
         out_pts_ff   <= OutPointsReset;
         en_ff        <= '0;
      end else if (wr) begin
         unique case (widx)
            REG_IN_START:   in_start_ff  <= pwdata[TW-1:0];
            REG_IN_END:     in_end_ff    <= pwdata[TW-1:0];
            REG_OUT_START:  out_start_ff <= pwdata[TW-1:0];
            REG_OUT_END:    out_end_ff   <= pwdata[TW-1:0];
            REG_IN_POINTS:  in_pts_ff    <= pwdata[31:0];
            REG_OUT_POINTS: out_pts_ff   <= pwdata[31:0];
            REG_ENABLES:    en_ff        <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (widx)
         REG_IN_START:   prdata = PW'($unsigned(in_start_ff));
         REG_IN_END:     prdata = PW'($unsigned(in_end_ff));
         REG_OUT_START:  prdata = PW'($unsigned(out_start_ff));
         REG_OUT_END:    prdata = PW'($unsigned(out_end_ff));
         REG_IN_POINTS:  prdata = PW'(in_pts_ff);
         REG_OUT_POINTS: prdata = PW'(out_pts_ff);
         REG_ENABLES:    prdata = PW'(en_ff);
         default:        prdata = '0;
      endcase
   end

   // Stage 1: comparisons.
   logic                 s1_valid_ff;
   logic signed [TW-1:0] s1_t_ff;
   logic                 s1_gt_oe_ff, s1_gt_is_ff, s1_le_ie_ff, s1_ge_os_ff, s1_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_t_ff     <= req_current_time;
      s1_gt_oe_ff <= req_current_time > out_end_ff;
      s1_gt_is_ff <= req_current_time > in_start_ff;
      s1_le_ie_ff <= req_current_time <= in_end_ff;
      s1_ge_os_ff <= req_current_time >= out_start_ff;
      s1_mode_ff  <= (in_start_ff >= out_start_ff) & en_ff[0] & en_ff[1];
   end

   // Stage 2: select operation and form divider operands.
   logic       s2_valid_ff;
   logic [1:0] s2_phase_ff;
   kind_type   s2_kind_ff;
   logic [DW-1:0] s2_num_ff, s2_den_ff;
   logic          s2_sat_ff;
   logic [31:0]   s2_pts_ff;

   logic [1:0] ph;
   kind_type   kind;
   logic signed [TW-1:0] ws, we;
   logic signed [DW-1:0] t1, s1x, e1x;
   logic [DW-1:0] num, den;
   logic          sat;

   always_comb begin
      ph   = PHASE_ONE;
      kind = KIND_CONST;
      if (s1_mode_ff) begin
         if (s1_gt_oe_ff) begin
            if (s1_gt_is_ff) begin
               if (s1_le_ie_ff) begin
                  ph = PHASE_IN;
                  kind = KIND_CURVE;
               end
            end else begin
               ph = PHASE_BLEND;
               kind = KIND_BLEND;
            end
         end else begin
            ph = PHASE_OUT;
            kind = KIND_CURVE;
         end
      end else begin
         if (en_ff[1] && s1_ge_os_ff) begin
            ph = PHASE_OUT;
            kind = KIND_CURVE;
         end
         if (en_ff[0] && s1_le_ie_ff) begin
            ph = PHASE_IN;
            kind = KIND_CURVE;
         end
      end
      if (ph == PHASE_IN) begin
         ws = in_start_ff;
         we = in_end_ff;
      end else if (ph == PHASE_BLEND) begin
         ws = out_end_ff;
         we = in_start_ff;
      end else begin
         ws = out_start_ff;
         we = out_end_ff;
      end
      t1  = DW'(s1_t_ff);
      s1x = DW'(ws);
      e1x = DW'(we);
      num = '0;
      den = DW'(1);
      sat = 1'b0;
      if (e1x == s1x) begin
         sat = !(t1 < s1x);
      end else if (e1x > s1x) begin
         if (t1 <= s1x) begin
            sat = 1'b0;
         end else if (t1 >= e1x) begin
            sat = 1'b1;
         end else begin
            num = DW'(t1 - s1x);
            den = DW'(e1x - s1x);
         end
      end else begin
         if (t1 >= s1x) begin
            sat = 1'b0;
         end else if (t1 <= e1x) begin
            sat = 1'b1;
         end else begin
            num = DW'(s1x - t1);
            den = DW'(s1x - e1x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_phase_ff <= ph;
      s2_kind_ff  <= kind;
      s2_num_ff   <= num;
      s2_den_ff   <= den;
      s2_sat_ff   <= sat;
      s2_pts_ff   <= (ph == PHASE_IN) ? in_pts_ff : out_pts_ff;
   end

   // Divider carries the kind, phase and control points alongside.
   logic [TGW-1:0] tag_in, tag_out;
   logic           d_valid;
   logic [16:0]    u;

   assign tag_in = {s2_phase_ff, s2_kind_ff == KIND_BLEND, s2_kind_ff == KIND_CURVE,
                    s2_pts_ff, out_pts_ff[31:24], in_pts_ff[7:0]};

   ecwm_divider #(.DW(DW), .TW(TGW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_sat    (s2_sat_ff),
      .in_tag    (tag_in),
      .out_valid (d_valid),
      .out_quot  (u),
      .out_tag   (tag_out)
   );

   logic [1:0] d_phase;
   logic       d_blend, d_curve;
   logic [7:0] p0, p1, p2, p3, bo3, bi0;
   assign d_phase = tag_out[TGW-1:TGW-2];
   assign d_blend = tag_out[TGW-3];
   assign d_curve = tag_out[48];
   assign {p3, p2, p1, p0} = tag_out[47:16];
   assign bo3 = tag_out[15:8];
   assign bi0 = tag_out[7:0];

   // Stage A: squares and blend products.
   logic        a_valid_ff, a_blend_ff, a_curve_ff;
   logic [1:0]  a_phase_ff;
   logic [16:0] a_u_ff, a_w_ff;
   logic [33:0] a_uu_ff, a_ww_ff;
   logic [7:0]  a_p0_ff, a_p1_ff, a_p2_ff, a_p3_ff;
   logic [24:0] a_bs_ff;
   logic [16:0] w_c;
   assign w_c = OneQ16 - u;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      a_phase_ff <= d_phase;
      a_blend_ff <= d_blend;
      a_curve_ff <= d_curve;
      a_u_ff     <= u;
      a_w_ff     <= w_c;
      a_uu_ff    <= u * u;
      a_ww_ff    <= w_c * w_c;
      a_p0_ff <= p0; a_p1_ff <= p1; a_p2_ff <= p2; a_p3_ff <= p3;
      a_bs_ff    <= 25'(w_c * bo3) + 25'(u * bi0);
   end

   // Stage B: Bernstein basis terms (scaled by points later).
   logic        b_valid_ff, b_blend_ff, b_curve_ff;
   logic [1:0]  b_phase_ff;
   logic [50:0] b_t0_ff, b_t1_ff, b_t2_ff, b_t3_ff;
   logic [7:0]  b_p0_ff, b_p1_ff, b_p2_ff, b_p3_ff;
   logic [24:0] b_bs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_phase_ff <= a_phase_ff;
      b_blend_ff <= a_blend_ff;
      b_curve_ff <= a_curve_ff;
      b_t0_ff <= 51'(a_ww_ff * a_w_ff);
      b_t1_ff <= 51'(a_ww_ff * a_u_ff);
      b_t2_ff <= 51'(a_uu_ff * a_w_ff);
      b_t3_ff <= 51'(a_uu_ff * a_u_ff);
      b_p0_ff <= a_p0_ff; b_p1_ff <= a_p1_ff; b_p2_ff <= a_p2_ff; b_p3_ff <= a_p3_ff;
      b_bs_ff <= a_bs_ff;
   end

   // Stage C: weight by control points.
   logic        c_valid_ff, c_blend_ff, c_curve_ff;
   logic [1:0]  c_phase_ff;
   logic [60:0] c_s0_ff, c_s1_ff;
   logic [24:0] c_bs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_phase_ff <= b_phase_ff;
      c_blend_ff <= b_blend_ff;
      c_curve_ff <= b_curve_ff;
      c_s0_ff <= 61'(b_t0_ff * b_p0_ff) + 61'(b_t3_ff * b_p3_ff);
      c_s1_ff <= 61'(b_t1_ff * b_p1_ff) + 61'(b_t2_ff * b_p2_ff);
      c_bs_ff <= b_bs_ff;
   end

   // Stage D: total sum with rounding bias; curve scales the sum down by 2^30.
   logic        d2_valid_ff, d2_blend_ff, d2_curve_ff;
   logic [1:0]  d2_phase_ff;
   logic [32:0] d2_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff <= 1'b0;
      end else begin
         d2_valid_ff <= c_valid_ff;
      end
   end

   logic [62:0] tot;
   assign tot = 63'(c_s0_ff) + 63'(3 * 63'(c_s1_ff)) + 63'(64'd255 << 31);

   always_ff @(posedge clock) begin
      d2_phase_ff <= c_phase_ff;
      d2_blend_ff <= c_blend_ff;
      d2_curve_ff <= c_curve_ff;
      d2_x_ff     <= c_blend_ff ? 33'(c_bs_ff + 25'd127) : tot[62:30];
   end

   // Stage E: divide by 255 with a reciprocal multiply and one correction.
   // Curve: q = floor(floor(tot / 2^30) / 1020) = floor(tot / (255 * 2^32)).
   logic        e_valid_ff;
   logic [1:0]  e_phase_ff;
   logic        e_kind_ff, e_curve_ff;
   logic [31:0] e_x255_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_phase_ff <= d2_phase_ff;
      e_kind_ff  <= d2_blend_ff;
      e_curve_ff <= d2_curve_ff;
      e_x255_ff  <= d2_blend_ff ? 32'(d2_x_ff) : 32'(d2_x_ff >> 2);
   end

   logic [63:0] qm;
   logic [31:0] qe;
   logic [40:0] rem;
   logic [16:0] qres;
   assign qm   = e_x255_ff * 64'h0000_0001_0101_0102 >> 40;
   always_comb begin
      qe   = qm[31:0];
      rem  = 41'(e_x255_ff) - 41'(qe * 255);
      if (rem >= 41'd255) begin
         qe = qe + 32'd1;
      end
      qres = qe[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_phase      <= e_phase_ff;
      rsp_multiplier <= (e_kind_ff || e_curve_ff) ? qres : OneQ16;
   end

endmodule
